FILE: rtl/core/bounding_box_track_table_assert.svh
// Assertion macros for the bounding box track table.
`ifndef BOUNDING_BOX_TRACK_TABLE_ASSERT_SVH
`define BOUNDING_BOX_TRACK_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define BBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define BBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define BBT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/bbt_pkg.sv
// Types and constants shared by the bounding box track table.
package bbt_pkg;

	localparam int MAX_TRACKS = 16;
	localparam int COORD_W    = 12;
	localparam int IDX_W      = $clog2(MAX_TRACKS);
	localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
	localparam int ID_W       = 4;
	localparam int CENTER_W   = 13;
	localparam int LIVE_W     = 5;
	localparam int AGE_W      = 8;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_MAX_AGE = '0;
	localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(12);

	localparam logic ACT_DETECT = 1'b0;
	localparam logic ACT_EOF    = 1'b1;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic   action;
		coord_t box_x;
		coord_t box_y;
		coord_t box_w;
		coord_t box_h;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]     track_number;
		logic                is_new_track;
		logic                dropped;
		logic [CENTER_W-1:0] prev_center_x;
		logic [CENTER_W-1:0] prev_center_y;
		logic [LIVE_W-1:0]   live_tracks;
	} result_t;

endpackage

FILE: rtl/core/bounding_box_track_table.sv
// Bounding box track table: greedy overlap tracker with a sequential slot walker.
`include "bounding_box_track_table_assert.svh"

// One item is taken at a time. A detection walks the live slots in order, one slot
// per cycle through a single overlap comparator, and stops at the first unmatched
// overlapping track; when nothing matches, a new track is opened, or the detection
// is dropped when all slots are in use. An end-of-frame item walks every live slot
// once, ageing and compacting the table in place. item_stall is high while an item
// is in work; a finished result sits in the output register, so the next item may
// enter while it waits. max_age is at byte address 0 of the register port; the user
// must write it only while idle, which the block itself does not enforce.
module bounding_box_track_table import bbt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                item_valid,
	output logic                item_stall,
	input  item_t               item,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EOF  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;
	localparam logic [AGE_W-1:0] AGE_SAT = '1;
	localparam int ID_N = 2 ** ID_W;

	logic [1:0]        state_q;
	logic [AGE_W-1:0]  max_age_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ridx_q;
	logic [CNT_W-1:0]  widx_q;
	logic [ID_N-1:0]   used_q;
	item_t             box_q;
	result_t           res_q;
	logic              result_valid_q;
	result_t           result_q;

	// slot storage, valid slots are 0 .. count_q-1
	logic [ID_W-1:0]    id_q     [MAX_TRACKS];
	coord_t             rect_x_q [MAX_TRACKS];
	coord_t             rect_y_q [MAX_TRACKS];
	coord_t             rect_w_q [MAX_TRACKS];
	coord_t             rect_h_q [MAX_TRACKS];
	logic [AGE_W-1:0]   age_q    [MAX_TRACKS];
	logic [MAX_TRACKS-1:0] matched_q;

	logic [IDX_W-1:0]   rd_idx;
	logic [ID_W-1:0]    rd_id;
	coord_t             rd_x, rd_y, rd_w, rd_h;
	logic [AGE_W-1:0]   rd_age;
	logic               rd_matched;
	logic               in_range;
	logic               hit;
	logic               full;
	logic [ID_W-1:0]    free_id;
	logic [AGE_W-1:0]   new_age;
	logic               keep;
	logic               out_free;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic [ID_W-1:0]    wr_id;
	coord_t             wr_x, wr_y, wr_w, wr_h;
	logic [AGE_W-1:0]   wr_age;

	logic               item_xfer;
	logic               cfg_wr;

	function automatic logic spans_meet(coord_t a0, coord_t alen, coord_t b0, coord_t blen);
		logic [COORD_W:0] lo;
		logic [COORD_W:0] ae;
		logic [COORD_W:0] be;
		logic [COORD_W:0] hi;
		lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
		ae = {1'b0, a0} + {1'b0, alen};
		be = {1'b0, b0} + {1'b0, blen};
		hi = (ae < be) ? ae : be;
		return hi > lo;
	endfunction

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign prdata    = (paddr[PADDR_W-1:2] == REG_MAX_AGE) ?
	                   {{(PDATA_W-AGE_W){1'b0}}, max_age_q} : '0;

	assign item_stall   = (state_q != S_IDLE);
	assign item_xfer    = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;

	// shared slot read port
	assign rd_idx     = ridx_q[IDX_W-1:0];
	assign rd_id      = id_q[rd_idx];
	assign rd_x       = rect_x_q[rd_idx];
	assign rd_y       = rect_y_q[rd_idx];
	assign rd_w       = rect_w_q[rd_idx];
	assign rd_h       = rect_h_q[rd_idx];
	assign rd_age     = age_q[rd_idx];
	assign rd_matched = matched_q[rd_idx];
	assign in_range   = (ridx_q < count_q);
	assign full       = (count_q == CNT_W'(MAX_TRACKS));

	// overlap test against the slot under the walker
	assign hit = in_range && !rd_matched &&
	             spans_meet(box_q.box_x, box_q.box_w, rd_x, rd_w) &&
	             spans_meet(box_q.box_y, box_q.box_h, rd_y, rd_h);

	// ageing of the slot under the walker at end of frame
	assign new_age = rd_matched ? '0 : ((rd_age == AGE_SAT) ? rd_age : rd_age + 1'b1);
	assign keep    = (new_age < max_age_q);

	// smallest ID not seen during the walk
	always_comb begin
		free_id = '0;
		for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
			if (!used_q[ID_W'(i)])
				free_id = ID_W'(i);
		end
	end

	// slot write port
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = rd_idx;
		wr_id  = rd_id;
		wr_x   = box_q.box_x;
		wr_y   = box_q.box_y;
		wr_w   = box_q.box_w;
		wr_h   = box_q.box_h;
		wr_age = '0;
		case (state_q)
			S_SCAN: begin
				if (hit) begin
					wr_en = 1'b1;
				end else if (!in_range && !full) begin
					wr_en  = 1'b1;
					wr_idx = count_q[IDX_W-1:0];
					wr_id  = free_id;
				end
			end
			S_EOF: begin
				wr_en  = in_range && keep;
				wr_idx = widx_q[IDX_W-1:0];
				wr_x   = rd_x;
				wr_y   = rd_y;
				wr_w   = rd_w;
				wr_h   = rd_h;
				wr_age = new_age;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q[wr_idx]     <= wr_id;
			rect_x_q[wr_idx] <= wr_x;
			rect_y_q[wr_idx] <= wr_y;
			rect_w_q[wr_idx] <= wr_w;
			rect_h_q[wr_idx] <= wr_h;
			age_q[wr_idx]    <= wr_age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= MAX_AGE_RESET;
		end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_MAX_AGE) begin
			max_age_q <= pwdata[AGE_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			matched_q <= '0;
			ridx_q    <= '0;
			widx_q    <= '0;
			used_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_xfer) begin
						ridx_q  <= '0;
						widx_q  <= '0;
						used_q  <= '0;
						state_q <= (item.action == ACT_EOF) ? S_EOF : S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						matched_q[rd_idx] <= 1'b1;
						state_q <= S_DONE;
					end else if (in_range) begin
						used_q[rd_id] <= 1'b1;
						ridx_q <= ridx_q + 1'b1;
					end else begin
						if (!full) begin
							matched_q[count_q[IDX_W-1:0]] <= 1'b1;
							count_q <= count_q + 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_EOF: begin
					if (in_range) begin
						if (keep)
							widx_q <= widx_q + 1'b1;
						ridx_q <= ridx_q + 1'b1;
					end else begin
						count_q   <= widx_q;
						matched_q <= '0;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: captured item and the result being built
	always_ff @(posedge clk) begin
		if (item_xfer)
			box_q <= item;
		case (state_q)
			S_IDLE: begin
				res_q <= '0;
			end
			S_SCAN: begin
				if (hit) begin
					res_q.track_number  <= rd_id;
					res_q.prev_center_x <= {1'b0, rd_x} + CENTER_W'(rd_w >> 1);
					res_q.prev_center_y <= {1'b0, rd_y} + CENTER_W'(rd_h >> 1);
					res_q.live_tracks   <= LIVE_W'(count_q);
				end else if (!in_range) begin
					if (full) begin
						res_q.dropped     <= 1'b1;
						res_q.live_tracks <= LIVE_W'(count_q);
					end else begin
						res_q.track_number <= free_id;
						res_q.is_new_track <= 1'b1;
						res_q.live_tracks  <= LIVE_W'(count_q + 1'b1);
					end
				end
			end
			S_EOF: begin
				if (!in_range)
					res_q.live_tracks <= LIVE_W'(widx_q);
			end
			default: begin
				res_q <= res_q;
			end
		endcase
		if (state_q == S_DONE && out_free)
			result_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	`BBT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_TRACKS))
	`BBT_ASSERT_IMP(a_drop_full, clk, arst_n, result_valid && result.dropped,
		result.live_tracks == LIVE_W'(MAX_TRACKS) && !result.is_new_track)
	`BBT_ASSERT_NXT(a_accept_busy, clk, arst_n, item_xfer, state_q != S_IDLE)
	`BBT_ASSERT_IMP(a_walk_bound, clk, arst_n, state_q == S_SCAN || state_q == S_EOF,
		ridx_q <= count_q && widx_q <= ridx_q)

endmodule

FILE: tb/sv/tb_bounding_box_track_table.sv
// Self-checking testbench for the bounding box track table: directed table plus random frames.
module tb_bounding_box_track_table;
	timeunit 1ns;
	timeprecision 1ps;

	import bbt_pkg::*;

	localparam int COORD_MAX  = (1 << COORD_W) - 1;
	localparam int IDLE_LIMIT = 2000;
	localparam int RAND_ITEMS = 750;
	localparam int END_WAIT   = 40;

	typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		item_t            it;
		logic [4:0]       reps;
		logic             pinned;
		result_t          want;
		logic [AGE_W-1:0] age_value;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               item_valid = 1'b0;
	logic               item_stall;
	item_t              item = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;

	// pinned expectation travels with the item it belongs to
	logic               item_pinned = 1'b0;
	result_t            item_want = '0;

	// predicted track table
	bit                 trk_valid [MAX_TRACKS];
	bit                 trk_seen  [MAX_TRACKS];
	logic [ID_W-1:0]    trk_id    [MAX_TRACKS];
	coord_t             trk_x     [MAX_TRACKS];
	coord_t             trk_y     [MAX_TRACKS];
	coord_t             trk_w     [MAX_TRACKS];
	coord_t             trk_h     [MAX_TRACKS];
	logic [AGE_W-1:0]   trk_age   [MAX_TRACKS];
	logic [AGE_W-1:0]   age_limit = MAX_AGE_RESET;

	result_t            track_q [$];
	int                 mismatches = 0;
	int                 results_seen = 0;
	int                 idle_cycles = 0;
	int                 burst_left = 0;
	int                 stall_run = 0;
	int                 stall_mode = 0;

	bounding_box_track_table uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int count_live();
		int n;
		n = 0;
		for (int i = 0; i < MAX_TRACKS; i++)
			if (trk_valid[i]) n++;
		return n;
	endfunction

	function automatic bit spans_overlap(int a0, int alen, int b0, int blen);
		int lo, hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
		return hi > lo;
	endfunction

	function automatic result_t track_predict(item_t it);
		result_t r;
		int hit, n, k, id;
		bit used;
		r = '0;
		if (it.action == ACT_EOF) begin
			k = 0;
			for (int i = 0; i < MAX_TRACKS; i++) begin
				if (trk_valid[i]) begin
					if (trk_seen[i])
						trk_age[i] = '0;
					else if (trk_age[i] != '1)
						trk_age[i] = trk_age[i] + 1'b1;
					trk_seen[i] = 1'b0;
					if (trk_age[i] < age_limit) begin
						// compact in place, survivors keep their order
						trk_valid[k] = 1'b1;
						trk_seen[k]  = 1'b0;
						trk_id[k]    = trk_id[i];
						trk_x[k]     = trk_x[i];
						trk_y[k]     = trk_y[i];
						trk_w[k]     = trk_w[i];
						trk_h[k]     = trk_h[i];
						trk_age[k]   = trk_age[i];
						k++;
					end
				end
			end
			for (int i = k; i < MAX_TRACKS; i++) begin
				trk_valid[i] = 1'b0;
				trk_seen[i]  = 1'b0;
			end
		end else begin
			hit = -1;
			for (int i = 0; i < MAX_TRACKS; i++)
				if (hit < 0 && trk_valid[i] && !trk_seen[i] &&
					spans_overlap(int'(it.box_x), int'(it.box_w),
						int'(trk_x[i]), int'(trk_w[i])) &&
					spans_overlap(int'(it.box_y), int'(it.box_h),
						int'(trk_y[i]), int'(trk_h[i])))
					hit = i;
			if (hit >= 0) begin
				r.track_number  = trk_id[hit];
				r.prev_center_x = CENTER_W'(trk_x[hit]) + CENTER_W'(trk_w[hit] >> 1);
				r.prev_center_y = CENTER_W'(trk_y[hit]) + CENTER_W'(trk_h[hit] >> 1);
				trk_x[hit]    = it.box_x;
				trk_y[hit]    = it.box_y;
				trk_w[hit]    = it.box_w;
				trk_h[hit]    = it.box_h;
				trk_age[hit]  = '0;
				trk_seen[hit] = 1'b1;
			end else begin
				n = count_live();
				if (n >= MAX_TRACKS) begin
					r.dropped = 1'b1;
				end else begin
					// smallest ID not held by a live track
					id = MAX_TRACKS;
					for (int c = MAX_TRACKS - 1; c >= 0; c--) begin
						used = 1'b0;
						for (int i = 0; i < MAX_TRACKS; i++)
							if (trk_valid[i] && trk_id[i] == ID_W'(c)) used = 1'b1;
						if (!used) id = c;
					end
					trk_valid[n] = 1'b1;
					trk_seen[n]  = 1'b1;
					trk_id[n]    = ID_W'(id);
					trk_x[n]     = it.box_x;
					trk_y[n]     = it.box_y;
					trk_w[n]     = it.box_w;
					trk_h[n]     = it.box_h;
					trk_age[n]   = '0;
					r.track_number = ID_W'(id);
					r.is_new_track = 1'b1;
				end
			end
		end
		r.live_tracks = LIVE_W'(count_live());
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		if (mismatches < 10) $display("mismatch: %s", what);
		mismatches++;
	endtask

	// sample everything at the clock edge, before the block updates its outputs
	always @(posedge clk) begin : monitor
		result_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (psel && penable && pready) begin
				if (pwrite && paddr[PADDR_W-1:2] == REG_MAX_AGE)
					age_limit = pwdata[AGE_W-1:0];
				else if (!pwrite && prdata[AGE_W-1:0] !== age_limit)
					flag_mismatch($sformatf("max_age read exp %0d got %0d",
						age_limit, prdata[AGE_W-1:0]));
			end
			if (result_valid && !result_stall) begin
				moved = 1'b1;
				if (track_q.size() == 0) begin
					flag_mismatch($sformatf("result %0d with nothing pending: %p",
						results_seen, result));
				end else begin
					want = track_q.pop_front();
					if (result.track_number !== want.track_number ||
						result.is_new_track !== want.is_new_track ||
						result.dropped !== want.dropped ||
						result.prev_center_x !== want.prev_center_x ||
						result.prev_center_y !== want.prev_center_y ||
						result.live_tracks !== want.live_tracks)
						flag_mismatch($sformatf("result %0d exp %p got %p",
							results_seen, want, result));
				end
				results_seen++;
			end
			if (item_valid && !item_stall) begin
				moved = 1'b1;
				want = track_predict(item);
				track_q = {track_q, (item_pinned ? item_want : want)};
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// result side: alternating stretches of free flow, light and heavy stalling
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run  = $urandom_range(8, 60);
		end else begin
			stall_run = stall_run - 1;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 1) == 0);
			default: result_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	function automatic item_t det(int x, int y, int w, int h);
		item_t it;
		it        = '0;
		it.action = ACT_DETECT;
		it.box_x  = coord_t'(x);
		it.box_y  = coord_t'(y);
		it.box_w  = coord_t'(w);
		it.box_h  = coord_t'(h);
		return it;
	endfunction

	function automatic item_t eof_item();
		item_t it;
		it        = '0;
		it.action = ACT_EOF;
		return it;
	endfunction

	function automatic result_t res(int id, int fresh, int drop, int cx, int cy, int live);
		result_t r;
		r.track_number  = ID_W'(id);
		r.is_new_track  = fresh[0];
		r.dropped       = drop[0];
		r.prev_center_x = CENTER_W'(cx);
		r.prev_center_y = CENTER_W'(cy);
		r.live_tracks   = LIVE_W'(live);
		return r;
	endfunction

	function automatic row_t row_item(item_t it, int reps, bit pin, result_t want);
		row_t r;
		r           = '0;
		r.kind      = ROW_ITEM;
		r.it        = it;
		r.reps      = 5'(reps);
		r.pinned    = pin;
		r.want      = want;
		return r;
	endfunction

	function automatic row_t row_cfg(int v);
		row_t r;
		r           = '0;
		r.kind      = ROW_CFG;
		r.age_value = AGE_W'(v);
		return r;
	endfunction

	function automatic coord_t nudge(coord_t v);
		int t;
		t = int'(v) + int'($urandom_range(0, 16)) - 8;
		if (t < 0) t = 0;
		else if (t > COORD_MAX) t = COORD_MAX;
		return coord_t'(t);
	endfunction

	// mostly boxes that follow a live track, then fresh boxes, noise and empty boxes
	function automatic item_t make_detection();
		item_t it;
		int live, pick, mode;
		live = count_live();
		mode = $urandom_range(0, 99);
		it   = det(0, 0, 0, 0);
		if (mode < 55 && live > 0) begin
			pick     = $urandom_range(0, live - 1);
			it.box_x = nudge(trk_x[pick]);
			it.box_y = nudge(trk_y[pick]);
			it.box_w = nudge(trk_w[pick]);
			it.box_h = nudge(trk_h[pick]);
		end else if (mode < 85) begin
			it.box_x = coord_t'($urandom_range(0, 3800));
			it.box_y = coord_t'($urandom_range(0, 3800));
			it.box_w = coord_t'($urandom_range(1, 300));
			it.box_h = coord_t'($urandom_range(1, 300));
		end else if (mode < 95) begin
			it.box_x = coord_t'($urandom_range(0, COORD_MAX));
			it.box_y = coord_t'($urandom_range(0, COORD_MAX));
			it.box_w = coord_t'($urandom_range(0, COORD_MAX));
			it.box_h = coord_t'($urandom_range(0, COORD_MAX));
		end else begin
			it.box_x = coord_t'($urandom_range(0, COORD_MAX));
			it.box_y = coord_t'($urandom_range(0, COORD_MAX));
			it.box_w = ($urandom_range(0, 1) == 0) ? '0 : coord_t'($urandom_range(0, 500));
			it.box_h = (it.box_w != '0) ? '0 : coord_t'($urandom_range(0, 500));
		end
		return it;
	endfunction

	// called just after the clock rises; returns on the rising clock at which the item is transferred
	task automatic offer(item_t it, bit pin, result_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
		end
		burst_left--;
		item        <= it;
		item_pinned <= pin;
		item_want   <= want;
		item_valid  <= 1'b1;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (track_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// write max_age, then read it back
	task automatic set_age_limit(logic [AGE_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_MAX_AGE, 2'b00};
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		row_t script [$];
		int sent, phase, phase_end, n_det;
		item_t it;

		script = {script, row_item(eof_item(), 1, 1, res(0, 0, 0, 0, 0, 0))};
		// empty rectangles never overlap, so each opens its own track
		script = {script, row_item(det(0, 0, 0, 0), 1, 1, res(0, 1, 0, 0, 0, 1))};
		script = {script, row_item(det(0, 0, 0, 0), 1, 1, res(1, 1, 0, 0, 0, 2))};
		script = {script, row_item(det(4095, 4095, 4095, 4095), 1, 1,
			res(2, 1, 0, 0, 0, 3))};
		// a track opened this frame is already matched
		script = {script, row_item(det(4095, 4095, 4095, 4095), 1, 1,
			res(3, 1, 0, 0, 0, 4))};
		script = {script, row_item(eof_item(), 1, 1, res(0, 0, 0, 0, 0, 4))};
		script = {script, row_item(det(4095, 4095, 1, 1), 1, 1,
			res(2, 0, 0, 6142, 6142, 4))};
		script = {script, row_item(det(4000, 4000, 200, 200), 1, 1,
			res(3, 0, 0, 6142, 6142, 4))};
		// fill the table
		script = {script, row_item(det(0, 0, 4095, 4095), 12, 0, '0)};
		script = {script, row_item(det(10, 10, 5, 5), 1, 1, res(0, 0, 1, 0, 0, 16))};
		script = {script, row_item(eof_item(), 1, 0, '0)};
		script = {script, row_cfg(1)};
		script = {script, row_item(eof_item(), 1, 1, res(0, 0, 0, 0, 0, 0))};
		script = {script, row_item(det(100, 100, 50, 50), 1, 1, res(0, 1, 0, 0, 0, 1))};
		// zero age limit clears the table at end of frame
		script = {script, row_cfg(0)};
		script = {script, row_item(eof_item(), 1, 1, res(0, 0, 0, 0, 0, 0))};
		script = {script, row_cfg(255)};
		script = {script, row_item(det(100, 100, 50, 50), 1, 1, res(0, 1, 0, 0, 0, 1))};
		script = {script, row_item(eof_item(), 1, 0, '0)};
		script = {script, row_item(det(120, 130, 10, 10), 1, 0, '0)};
		script = {script, row_item(det(149, 149, 1, 1), 1, 0, '0)};
		// touching edges have no common area
		script = {script, row_item(det(150, 150, 4, 4), 1, 0, '0)};
		script = {script, row_item(eof_item(), 1, 0, '0)};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			if (script[r].kind == ROW_CFG) begin
				drain();
				set_age_limit(script[r].age_value);
			end else begin
				repeat (script[r].reps) offer(script[r].it, script[r].pinned, script[r].want);
			end
		end

		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			drain();
			case (phase % 6)
				0: set_age_limit(AGE_W'(3));
				1: set_age_limit(AGE_W'(255));
				2: set_age_limit(AGE_W'(1));
				3: set_age_limit(AGE_W'($urandom_range(1, 255)));
				4: set_age_limit(AGE_W'(2));
				default: set_age_limit(MAX_AGE_RESET);
			endcase
			phase_end = sent + $urandom_range(60, 120);
			while (sent < phase_end) begin
				n_det = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20)
					: $urandom_range(0, 8);
				repeat (n_det) begin
					offer(make_detection(), 1'b0, '0);
					sent++;
				end
				// payload of an end-of-frame item is don't-care
				it       = eof_item();
				it.box_x = coord_t'($urandom_range(0, COORD_MAX));
				it.box_y = coord_t'($urandom_range(0, COORD_MAX));
				it.box_w = coord_t'($urandom_range(0, COORD_MAX));
				it.box_h = coord_t'($urandom_range(0, COORD_MAX));
				offer(it, 1'b0, '0);
				sent++;
			end
			phase++;
		end

		drain();
		repeat (END_WAIT) @(posedge clk);
		if (mismatches == 0 && track_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bbt_pkg.sv
rtl/core/bounding_box_track_table.sv
tb/sv/tb_bounding_box_track_table.sv
